### src/gbn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants of the grid bucket nearest point index.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int COORD_W   = 24;   // signed coordinate, 8 fraction bits
    localparam int ID_W      = 21;   // signed id on the ports
    localparam int SID_W     = 20;   // stored id
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 24;
    localparam int DIFF_W    = COORD_W + 1;      // coordinate difference
    localparam int SQ_W      = 2 * COORD_W;      // one squared difference
    localparam int DIST_W    = SQ_W + 2;         // sum of three squares
    localparam int ROOT_W    = DIST_W / 2 + 1;   // ceiling root
    localparam int DIV_W     = COORD_W + 4;      // dividend of a cell division
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int SQRT_CNT_W = $clog2(DIST_W / 2);

    localparam logic signed [ID_W-1:0] NONE_ID = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z   = 3'd5;

    typedef enum logic [STATUS_W-1:0] {
        STS_ADDED = 3'd0,
        STS_OOB   = 3'd1,
        STS_FULL  = 3'd2,
        STS_FOUND = 3'd3,
        STS_NONE  = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_CELL_CHK,
        S_ADD_RD,
        S_ADD_FILL,
        S_DELTA,
        S_BOX_INIT,
        S_SCAN_CELL,
        S_SCAN_FILL,
        S_PT_RD,
        S_PT_MX,
        S_PT_MY,
        S_PT_MZ,
        S_PT_CMP,
        S_NEXT_CELL,
        S_SQRT_START,
        S_SQRT_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [SID_W-1:0]          ident;
    } point_t;

endpackage

`default_nettype wire

### src/gbn_intf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_intf
// Valid/ready channels: request items in, result items out.
// ----------------------------------------------------------------------------
interface gbn_in_if import gbn_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic signed [ID_W-1:0]    point_ident;

    modport source (output valid, action, coord_x, coord_y, coord_z, point_ident,
                    input ready);
    modport sink (input valid, action, coord_x, coord_y, coord_z, point_ident,
                  output ready);
endinterface

interface gbn_out_if import gbn_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic signed [ID_W-1:0] found_ident;

    modport source (output valid, status, found_ident, input ready);
    modport sink (input valid, status, found_ident, output ready);
endinterface

`default_nettype wire

### src/gbn_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_div
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module gbn_div import gbn_pkg::*; (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [DIV_W-1:0]  dividend,
    input  wire logic [CFG_W-1:0]         divisor,
    output logic                          done,
    output logic signed [DIV_W-1:0]       quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 neg_reg;
    logic [DIV_W-1:0]     mq_reg;
    logic [CFG_W-1:0]     rem_reg;
    logic [CFG_W-1:0]     dsr_reg;
    logic [CFG_W:0]       rem_sh;
    logic                 fits;

    assign rem_sh = {rem_reg, mq_reg[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[DIV_W-1];
            mq_reg  <= dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
            rem_reg <= '0;
            dsr_reg <= (divisor == '0) ? CFG_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            mq_reg  <= {mq_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? CFG_W'(rem_sh - {1'b0, dsr_reg}) : rem_sh[CFG_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(mq_reg) : $signed(mq_reg);

endmodule

`default_nettype wire

### src/gbn_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_sqrt
// Digit-by-digit square root, two radicand bits per cycle, rounds up.
// ----------------------------------------------------------------------------
module gbn_sqrt import gbn_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIST_W-1:0] radicand,
    output logic                   done,
    output logic [ROOT_W-1:0]      root
);

    localparam int STEPS = DIST_W / 2;
    localparam int REM_W = STEPS + 3;

    logic                  busy_reg;
    logic                  done_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic [DIST_W-1:0]     rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [STEPS-1:0]      root_reg;
    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      trial;
    logic                  fits;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[DIST_W-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SQRT_CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[DIST_W-3:0], 2'b00};
            rem_reg  <= fits ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[STEPS-2:0], fits};
        end
    end

    // nonzero remainder: floor root is short of the ceiling by one
    assign done = done_reg;
    assign root = ROOT_W'(root_reg) + ROOT_W'(rem_reg != '0);

endmodule

`default_nettype wire

### src/grid_bucket_nearest_point.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_bucket_nearest_point
// 3D point index over a uniform grid: adds points, finds the nearest one.
// ----------------------------------------------------------------------------
// One item at a time. Each item first maps its position to a cell with three
// divisions on a shared radix-2 divider. An add then goes through cell
// check, fill read, write and output. A query scans its own cell, then
// grows a cube of cells until one holds a point; every cell and stored
// point is read through one fill memory read port, one point memory read
// port and one 25x25 multiplier. After that a square root and six more
// divisions set the recheck window, whose cells are scanned the same way.
// A sparse grid lengthens a query by the cube growth. After reset the
// block clears the per-cell fill counts, one cell a cycle, and takes no
// item meanwhile; configuration writes are taken at any time. The result
// sits in an output register, so the next item is taken while it waits.
// ----------------------------------------------------------------------------
module grid_bucket_nearest_point import gbn_pkg::*; #(
    parameter int GRID_X        = 8,
    parameter int GRID_Y        = 8,
    parameter int GRID_Z        = 8,
    parameter int CELL_CAPACITY = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    gbn_in_if.sink                    in_ch,
    gbn_out_if.source                 out_ch,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int NUM_CELLS = GRID_X * GRID_Y * GRID_Z;
    localparam int NUM_SLOTS = NUM_CELLS * CELL_CAPACITY;
    localparam int XW = (GRID_X > 1) ? $clog2(GRID_X) : 1;
    localparam int YW = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
    localparam int ZW = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
    localparam int MW = (XW > YW) ? ((XW > ZW) ? XW : ZW) : ((YW > ZW) ? YW : ZW);
    localparam int DLW = MW + 2;                 // signed cell +/- growth
    localparam int CW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int FW = $clog2(CELL_CAPACITY + 1);

    // ---------------- configuration registers ----------------
    logic signed [COORD_W-1:0] org_reg [3];
    logic [CFG_W-1:0]          size_reg [3];

    // ---------------- control state ----------------
    state_t             state_reg, state_next;
    logic [CW-1:0]      clr_reg;
    logic [SID_W-1:0]   auto_reg;
    logic               ovalid_reg;
    status_t            ostatus_reg;
    logic signed [ID_W-1:0] oident_reg;

    // ---------------- item datapath ----------------
    logic                      act_reg;
    logic signed [COORD_W-1:0] q_reg [3];
    logic signed [ID_W-1:0]    pid_reg;
    logic                      phase_b_reg;  // recheck pass
    logic [2:0]                cnt_reg;      // division index
    logic                      outside_reg;
    logic [MW-1:0]             c_reg [3];
    logic [MW-1:0]             lo_reg [3];
    logic [MW-1:0]             hi_reg [3];
    logic [MW-1:0]             idx_reg [3];
    logic [MW:0]               delta_reg;
    logic [FW-1:0]             n_reg;
    logic [FW-1:0]             slot_reg;
    logic [SQ_W-1:0]           prod_reg;
    logic [DIST_W-1:0]         acc_reg;
    logic                      best_valid_reg;
    logic [DIST_W-1:0]         best_d_reg;
    logic [SID_W-1:0]          best_id_reg;
    logic [ROOT_W-1:0]         r_reg;
    status_t                   res_status_reg;

    // ---------------- memories ----------------
    logic [FW-1:0] fill_mem [NUM_CELLS];
    point_t        pt_mem [NUM_SLOTS];
    logic [FW-1:0] fill_q;
    point_t        pt_q;

    // ---------------- control strobes ----------------
    logic          in_ready;
    logic          accept;
    logic          div_start, div_done;
    logic          sqrt_start, sqrt_done;
    logic          fill_we, fill_re;
    logic [CW-1:0] fill_waddr, fill_raddr;
    logic [FW-1:0] fill_wdata;
    logic          pt_we, pt_re;
    logic [AW-1:0] pt_addr;
    logic          out_load;

    // ---------------- helpers ----------------
    function automatic logic [MW-1:0] axis_lim(input logic [1:0] ax);
        logic [MW-1:0] v;
        case (ax)
            2'd0:    v = MW'(GRID_X - 1);
            2'd1:    v = MW'(GRID_Y - 1);
            default: v = MW'(GRID_Z - 1);
        endcase
        return v;
    endfunction

    function automatic logic [MW-1:0] clamp_q(input logic signed [DIV_W-1:0] q,
                                              input logic [1:0] ax);
        logic [MW-1:0] v;
        if (q < 0)
            v = '0;
        else if (q > $signed(DIV_W'(axis_lim(ax))))
            v = axis_lim(ax);
        else
            v = q[MW-1:0];
        return v;
    endfunction

    function automatic logic [MW-1:0] clamp_d(input logic signed [DLW-1:0] q,
                                              input logic [1:0] ax);
        logic [MW-1:0] v;
        if (q < 0)
            v = '0;
        else if (q > $signed(DLW'(axis_lim(ax))))
            v = axis_lim(ax);
        else
            v = q[MW-1:0];
        return v;
    endfunction

    function automatic logic [CW-1:0] cell_of(input logic [MW-1:0] i,
                                              input logic [MW-1:0] j,
                                              input logic [MW-1:0] k);
        return CW'(i) + CW'(j) * CW'(GRID_X) + CW'(k) * CW'(GRID_X * GRID_Y);
    endfunction

    function automatic logic [AW-1:0] slot_of(input logic [CW-1:0] cell_idx,
                                              input logic [FW-1:0] n);
        return AW'(cell_idx) * AW'(CELL_CAPACITY) + AW'(n);
    endfunction

    // ---------------- divider operand select ----------------
    logic [1:0]                ax;
    logic signed [DIV_W-1:0]   dividend;
    logic signed [DIV_W-1:0]   div_q;
    logic signed [DIV_W-1:0]   off;
    logic                      q_out;

    assign ax  = phase_b_reg ? cnt_reg[2:1] : cnt_reg[1:0];
    assign off = !phase_b_reg ? '0 :
                 (cnt_reg[0] ? $signed(DIV_W'(r_reg)) : -$signed(DIV_W'(r_reg)));
    assign dividend = $signed(DIV_W'(q_reg[ax])) - $signed(DIV_W'(org_reg[ax])) + off;
    assign q_out = (div_q < 0) || (div_q > $signed(DIV_W'(axis_lim(ax))));

    gbn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (size_reg[ax]),
        .done     (div_done),
        .quotient (div_q)
    );

    logic [ROOT_W-1:0] sqrt_root;

    gbn_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (best_d_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // ---------------- distance: one squarer shared over three axes ----------------
    logic signed [COORD_W-1:0]  mul_p, mul_q;
    logic signed [DIFF_W-1:0]   mul_a;
    logic signed [2*DIFF_W-1:0] prod_full;
    logic [DIST_W-1:0]          pt_dist;

    always_comb
    begin
        unique case (state_reg)
            S_PT_MX:
            begin
                mul_p = pt_q.x;
                mul_q = q_reg[0];
            end
            S_PT_MY:
            begin
                mul_p = pt_q.y;
                mul_q = q_reg[1];
            end
            default:
            begin
                mul_p = pt_q.z;
                mul_q = q_reg[2];
            end
        endcase
    end

    assign mul_a     = DIFF_W'(mul_p) - DIFF_W'(mul_q);
    assign prod_full = mul_a * mul_a;
    assign pt_dist   = acc_reg + DIST_W'(prod_reg);

    // ---------------- scan order ----------------
    logic          box_last, box_full;
    logic [CW-1:0] scan_cell, home_cell;

    assign box_last = (idx_reg[0] == hi_reg[0]) && (idx_reg[1] == hi_reg[1]) &&
                      (idx_reg[2] == hi_reg[2]);
    assign box_full = (lo_reg[0] == '0) && (lo_reg[1] == '0) && (lo_reg[2] == '0) &&
                      (hi_reg[0] == axis_lim(2'd0)) && (hi_reg[1] == axis_lim(2'd1)) &&
                      (hi_reg[2] == axis_lim(2'd2));
    assign scan_cell = cell_of(idx_reg[0], idx_reg[1], idx_reg[2]);
    assign home_cell = cell_of(c_reg[0], c_reg[1], c_reg[2]);

    logic add_ok;
    assign add_ok = (fill_q < FW'(CELL_CAPACITY));
    assign accept = in_ch.valid && in_ready;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:      if (clr_reg == CW'(NUM_CELLS - 1)) state_next = S_IDLE;
            S_IDLE:       if (accept) state_next = S_DIV_START;
            S_DIV_START:  state_next = S_DIV_WAIT;
            S_DIV_WAIT:
                if (div_done)
                begin
                    if (!phase_b_reg && cnt_reg == 3'd2)
                        state_next = S_CELL_CHK;
                    else if (phase_b_reg && cnt_reg == 3'd5)
                        state_next = S_BOX_INIT;
                    else
                        state_next = S_DIV_START;
                end
            S_CELL_CHK:
                if (outside_reg)
                    state_next = S_OUT;
                else if (!act_reg)
                    state_next = S_ADD_RD;
                else
                    state_next = S_DELTA;
            S_ADD_RD:     state_next = S_ADD_FILL;
            S_ADD_FILL:   state_next = S_OUT;
            S_DELTA:      state_next = S_BOX_INIT;
            S_BOX_INIT:   state_next = S_SCAN_CELL;
            S_SCAN_CELL:  state_next = S_SCAN_FILL;
            S_SCAN_FILL:  state_next = (fill_q == '0) ? S_NEXT_CELL : S_PT_RD;
            S_PT_RD:      state_next = S_PT_MX;
            S_PT_MX:      state_next = S_PT_MY;
            S_PT_MY:      state_next = S_PT_MZ;
            S_PT_MZ:      state_next = S_PT_CMP;
            S_PT_CMP:     state_next = (slot_reg + 1'b1 == n_reg) ? S_NEXT_CELL : S_PT_RD;
            S_NEXT_CELL:
                if (!phase_b_reg && best_valid_reg)
                    state_next = S_SQRT_START;
                else if (!box_last)
                    state_next = S_SCAN_CELL;
                else if (phase_b_reg || box_full)
                    state_next = S_OUT;
                else
                    state_next = S_DELTA;
            S_SQRT_START: state_next = S_SQRT_WAIT;
            S_SQRT_WAIT:  if (sqrt_done) state_next = S_DIV_START;
            S_OUT:        if (!ovalid_reg || out_ch.ready) state_next = S_IDLE;
            default:      state_next = S_CLEAR;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb
    begin
        in_ready   = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        fill_we    = 1'b0;
        fill_waddr = home_cell;
        fill_wdata = fill_q + 1'b1;
        fill_re    = 1'b0;
        fill_raddr = scan_cell;
        pt_we      = 1'b0;
        pt_re      = 1'b0;
        pt_addr    = slot_of(scan_cell, slot_reg);
        out_load   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                fill_we    = 1'b1;
                fill_waddr = clr_reg;
                fill_wdata = '0;
            end
            S_IDLE:       in_ready = 1'b1;
            S_DIV_START:  div_start = 1'b1;
            S_ADD_RD:
            begin
                fill_re    = 1'b1;
                fill_raddr = home_cell;
            end
            S_ADD_FILL:
            begin
                fill_we = add_ok;
                pt_we   = add_ok;
                pt_addr = slot_of(home_cell, fill_q);
            end
            S_SCAN_CELL:  fill_re = 1'b1;
            S_PT_RD:      pt_re = 1'b1;
            S_SQRT_START: sqrt_start = 1'b1;
            S_OUT:        out_load = !ovalid_reg || out_ch.ready;
            default:      ;
        endcase
    end

    // ---------------- memories ----------------
    point_t pt_wdata;
    assign pt_wdata.x     = q_reg[0];
    assign pt_wdata.y     = q_reg[1];
    assign pt_wdata.z     = q_reg[2];
    assign pt_wdata.ident = pid_reg[ID_W-1] ? auto_reg : pid_reg[SID_W-1:0];

    always_ff @(posedge clk)
    begin
        if (fill_we)
            fill_mem[fill_waddr] <= fill_wdata;
        if (fill_re)
            fill_q <= fill_mem[fill_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
            pt_mem[pt_addr] <= pt_wdata;
        if (pt_re)
            pt_q <= pt_mem[pt_addr];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            auto_reg    <= '0;
            ovalid_reg  <= 1'b0;
            org_reg[0]  <= '0;
            org_reg[1]  <= '0;
            org_reg[2]  <= '0;
            size_reg[0] <= CFG_W'(256);
            size_reg[1] <= CFG_W'(256);
            size_reg[2] <= CFG_W'(256);
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == S_ADD_FILL && add_ok)
                auto_reg <= auto_reg + 1'b1;
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ORIGIN_X: org_reg[0]  <= $signed(cfg_data);
                    CFG_ORIGIN_Y: org_reg[1]  <= $signed(cfg_data);
                    CFG_ORIGIN_Z: org_reg[2]  <= $signed(cfg_data);
                    CFG_SIZE_X:   size_reg[0] <= cfg_data;
                    CFG_SIZE_Y:   size_reg[1] <= cfg_data;
                    CFG_SIZE_Z:   size_reg[2] <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    // ---------------- item datapath ----------------
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ostatus_reg <= res_status_reg;
            oident_reg  <= (res_status_reg == STS_FOUND) ?
                           $signed({1'b0, best_id_reg}) : NONE_ID;
        end
        unique case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    act_reg        <= in_ch.action;
                    q_reg[0]       <= in_ch.coord_x;
                    q_reg[1]       <= in_ch.coord_y;
                    q_reg[2]       <= in_ch.coord_z;
                    pid_reg        <= in_ch.point_ident;
                    phase_b_reg    <= 1'b0;
                    cnt_reg        <= '0;
                    outside_reg    <= 1'b0;
                    best_valid_reg <= 1'b0;
                end
            S_DIV_WAIT:
                if (div_done)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (!phase_b_reg)
                    begin
                        c_reg[ax] <= clamp_q(div_q, ax);
                        if (q_out)
                            outside_reg <= 1'b1;
                    end
                    else if (cnt_reg[0])
                        hi_reg[ax] <= clamp_q(div_q, ax);
                    else
                        lo_reg[ax] <= clamp_q(div_q, ax);
                end
            S_CELL_CHK:
            begin
                delta_reg      <= '0;
                res_status_reg <= act_reg ? STS_NONE : STS_OOB;
            end
            S_ADD_FILL:
                res_status_reg <= add_ok ? STS_ADDED : STS_FULL;
            S_DELTA:
                for (int a = 0; a < 3; a++)
                begin
                    lo_reg[a] <= clamp_d($signed(DLW'(c_reg[a])) - $signed(DLW'(delta_reg)),
                                         2'(a));
                    hi_reg[a] <= clamp_d($signed(DLW'(c_reg[a])) + $signed(DLW'(delta_reg)),
                                         2'(a));
                end
            S_BOX_INIT:
            begin
                idx_reg[0] <= lo_reg[0];
                idx_reg[1] <= lo_reg[1];
                idx_reg[2] <= lo_reg[2];
            end
            S_SCAN_FILL:
            begin
                n_reg    <= fill_q;
                slot_reg <= '0;
            end
            S_PT_MX:
                prod_reg <= prod_full[SQ_W-1:0];
            S_PT_MY:
            begin
                acc_reg  <= DIST_W'(prod_reg);
                prod_reg <= prod_full[SQ_W-1:0];
            end
            S_PT_MZ:
            begin
                acc_reg  <= acc_reg + DIST_W'(prod_reg);
                prod_reg <= prod_full[SQ_W-1:0];
            end
            S_PT_CMP:
            begin
                slot_reg <= slot_reg + 1'b1;
                // strict compare keeps the earlier point on a tie
                if (!best_valid_reg || pt_dist < best_d_reg)
                begin
                    best_valid_reg <= 1'b1;
                    best_d_reg     <= pt_dist;
                    best_id_reg    <= pt_q.ident;
                end
            end
            S_NEXT_CELL:
                if (phase_b_reg || !best_valid_reg)
                begin
                    if (!box_last)
                    begin
                        // k fastest, then j, then i
                        if (idx_reg[2] != hi_reg[2])
                            idx_reg[2] <= idx_reg[2] + 1'b1;
                        else
                        begin
                            idx_reg[2] <= lo_reg[2];
                            if (idx_reg[1] != hi_reg[1])
                                idx_reg[1] <= idx_reg[1] + 1'b1;
                            else
                            begin
                                idx_reg[1] <= lo_reg[1];
                                idx_reg[0] <= idx_reg[0] + 1'b1;
                            end
                        end
                    end
                    else if (phase_b_reg)
                        res_status_reg <= STS_FOUND;
                    else if (box_full)
                        res_status_reg <= STS_NONE;
                    else
                        delta_reg <= delta_reg + 1'b1;
                end
            S_SQRT_WAIT:
                if (sqrt_done)
                begin
                    r_reg       <= sqrt_root;
                    phase_b_reg <= 1'b1;
                    cnt_reg     <= '0;
                end
            default: ;
        endcase
    end

    assign in_ch.ready        = in_ready;
    assign out_ch.valid       = ovalid_reg;
    assign out_ch.status      = ostatus_reg;
    assign out_ch.found_ident = oident_reg;

endmodule

`default_nettype wire

### tb/gbn_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_checker
// Watches the request and result channels of the grid index. It keeps its
// own copy of the grid contents and computes the expected result for each
// accepted item. Each result is checked against the oldest open expectation.
// ----------------------------------------------------------------------------
module gbn_checker import gbn_pkg::*; #(
    parameter int GRID_X        = 8,
    parameter int GRID_Y        = 8,
    parameter int GRID_Z        = 8,
    parameter int CELL_CAPACITY = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    gbn_in_if                         in_mon,
    gbn_out_if                        out_mon,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output int                        fail_count,
    output int                        pending
);

    localparam int NCELLS = GRID_X * GRID_Y * GRID_Z;
    localparam int NSLOTS = NCELLS * CELL_CAPACITY;

    typedef struct {
        status_t                status;
        logic signed [ID_W-1:0] ident;
    } answer_t;

    answer_t  answer_q[$];

    int       cell_cnt [NCELLS];
    longint   pt_x     [NSLOTS];
    longint   pt_y     [NSLOTS];
    longint   pt_z     [NSLOTS];
    logic [SID_W-1:0] pt_id [NSLOTS];
    logic [SID_W-1:0] next_id;
    longint   org  [3];
    longint   csz  [3];

    // Division truncates toward zero; a zero size counts as one.
    function automatic longint cell_of(longint pos, longint o, longint sz);
        longint d;
        d = (sz == 0) ? 1 : sz;
        return (pos - o) / d;
    endfunction

    function automatic longint clip(longint v, longint hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint root_up(longint v);
        longint r;
        r = longint'($sqrt(real'(v)));
        while (r * r > v) r--;
        while ((r + 1) * (r + 1) <= v) r++;
        if (r * r < v) r++;
        return r;
    endfunction

    function automatic int flat(longint i, longint j, longint k);
        return int'(i + j * GRID_X + k * GRID_X * GRID_Y);
    endfunction

    // Nearest slot of one cell, -1 if the cell is empty.
    function automatic int nearest_in_cell(int c, longint qx, longint qy, longint qz,
                                           output longint dsq);
        int     best;
        int     s;
        longint dx, dy, dz, d;
        best = -1;
        dsq  = 0;
        for (int n = 0; n < cell_cnt[c] && n < CELL_CAPACITY; n++) begin
            s  = c * CELL_CAPACITY + n;
            dx = pt_x[s] - qx;
            dy = pt_y[s] - qy;
            dz = pt_z[s] - qz;
            d  = dx * dx + dy * dy + dz * dz;
            if (best < 0 || d < dsq) begin
                best = s;
                dsq  = d;
            end
        end
        return best;
    endfunction

    function automatic answer_t predict(logic act, longint qx, longint qy, longint qz,
                                        longint pid);
        answer_t a;
        longint  ci, cj, ck, dl, r, bd, d;
        longint  i0, i1, j0, j1, k0, k1;
        longint  lo[3], hi[3];
        int      c, best, s;
        bit      hit, found;
        a.ident = NONE_ID;
        ci  = cell_of(qx, org[0], csz[0]);
        cj  = cell_of(qy, org[1], csz[1]);
        ck  = cell_of(qz, org[2], csz[2]);
        hit = ci >= 0 && ci < GRID_X && cj >= 0 && cj < GRID_Y && ck >= 0 && ck < GRID_Z;
        if (act == 1'b0) begin
            if (!hit) begin
                a.status = STS_OOB;
                return a;
            end
            c = flat(ci, cj, ck);
            if (cell_cnt[c] >= CELL_CAPACITY) begin
                a.status = STS_FULL;
                return a;
            end
            s = c * CELL_CAPACITY + cell_cnt[c];
            pt_x[s]  = qx;
            pt_y[s]  = qy;
            pt_z[s]  = qz;
            pt_id[s] = (pid < 0) ? next_id : pid[SID_W-1:0];
            cell_cnt[c]++;
            next_id++;
            a.status = STS_ADDED;
            return a;
        end
        if (!hit) begin
            a.status = STS_NONE;
            return a;
        end
        best = nearest_in_cell(flat(ci, cj, ck), qx, qy, qz, bd);
        if (best < 0) begin
            // grow a cube until some cell holds a point; first one in scan order wins
            found = 0;
            dl    = 1;
            while (!found) begin
                i0 = clip(ci - dl, GRID_X - 1); i1 = clip(ci + dl, GRID_X - 1);
                j0 = clip(cj - dl, GRID_Y - 1); j1 = clip(cj + dl, GRID_Y - 1);
                k0 = clip(ck - dl, GRID_Z - 1); k1 = clip(ck + dl, GRID_Z - 1);
                for (longint i = i0; i <= i1 && !found; i++)
                    for (longint j = j0; j <= j1 && !found; j++)
                        for (longint k = k0; k <= k1 && !found; k++) begin
                            best = nearest_in_cell(flat(i, j, k), qx, qy, qz, bd);
                            if (best >= 0) found = 1;
                        end
                if (!found && i0 == 0 && i1 == GRID_X - 1 && j0 == 0 &&
                    j1 == GRID_Y - 1 && k0 == 0 && k1 == GRID_Z - 1)
                    break;
                dl++;
            end
            if (!found) begin
                a.status = STS_NONE;
                return a;
            end
        end
        r     = root_up(bd);
        lo[0] = clip(cell_of(qx - r, org[0], csz[0]), GRID_X - 1);
        hi[0] = clip(cell_of(qx + r, org[0], csz[0]), GRID_X - 1);
        lo[1] = clip(cell_of(qy - r, org[1], csz[1]), GRID_Y - 1);
        hi[1] = clip(cell_of(qy + r, org[1], csz[1]), GRID_Y - 1);
        lo[2] = clip(cell_of(qz - r, org[2], csz[2]), GRID_Z - 1);
        hi[2] = clip(cell_of(qz + r, org[2], csz[2]), GRID_Z - 1);
        for (longint i = lo[0]; i <= hi[0]; i++)
            for (longint j = lo[1]; j <= hi[1]; j++)
                for (longint k = lo[2]; k <= hi[2]; k++) begin
                    s = nearest_in_cell(flat(i, j, k), qx, qy, qz, d);
                    if (s >= 0 && d < bd) begin
                        bd   = d;
                        best = s;
                    end
                end
        a.status = STS_FOUND;
        a.ident  = {1'b0, pt_id[best]};
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n) begin
            foreach (cell_cnt[c]) cell_cnt[c] = 0;
            next_id = '0;
            org     = '{0, 0, 0};
            csz     = '{256, 256, 256};
            answer_q.delete();
            fail_count = 0;
            pending    = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ORIGIN_X: org[0] = longint'(signed'(cfg_data));
                    CFG_ORIGIN_Y: org[1] = longint'(signed'(cfg_data));
                    CFG_ORIGIN_Z: org[2] = longint'(signed'(cfg_data));
                    CFG_SIZE_X:   csz[0] = longint'(cfg_data);
                    CFG_SIZE_Y:   csz[1] = longint'(cfg_data);
                    CFG_SIZE_Z:   csz[2] = longint'(cfg_data);
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready)
                answer_q.insert(answer_q.size(),
                                predict(in_mon.action, longint'(in_mon.coord_x),
                                        longint'(in_mon.coord_y),
                                        longint'(in_mon.coord_z),
                                        longint'(in_mon.point_ident)));
            if (out_mon.valid && out_mon.ready) begin
                if (answer_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: status %0d id %0d",
                                 out_mon.status, out_mon.found_ident);
                end else begin
                    want = answer_q.pop_front();
                    if (out_mon.status !== want.status ||
                        out_mon.found_ident !== want.ident) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected status %0d id %0d, got %0d id %0d",
                                     want.status, want.ident, out_mon.status,
                                     out_mon.found_ident);
                    end
                end
            end
            pending = answer_q.size();
        end
    end

endmodule

`default_nettype wire

### tb/tb_grid_bucket_nearest_point.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_grid_bucket_nearest_point
// Drives adds and nearest-point queries into the grid index over several
// grid settings. A checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_grid_bucket_nearest_point;
    import gbn_pkg::*;

    localparam int GRID_N     = 8;     // cells per axis
    localparam int IDLE_LIMIT = 200000; // cycles with no handshake at all
    localparam int LONG_HOLD  = 3000;   // the one long result stall

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int   fail_count;
    int   pending;
    int   idle_cycles;

    // settings as last written, used to aim points into the grid
    longint cur_org [3];
    longint cur_sz  [3];

    // sender burst bookkeeping
    int   burst_left;
    // receiver long hold: requested here, served by the receiver process
    bit   hold_req;
    bit   hold_done;
    int   hold_left;
    int   rx_cycle;
    int   rx_mode;

    gbn_in_if  in_ch ();
    gbn_out_if out_ch ();

    always #1 clk = ~clk;

    grid_bucket_nearest_point #(
        .GRID_X(GRID_N), .GRID_Y(GRID_N), .GRID_Z(GRID_N), .CELL_CAPACITY(8)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    gbn_checker #(
        .GRID_X(GRID_N), .GRID_Y(GRID_N), .GRID_Z(GRID_N), .CELL_CAPACITY(8)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_mon    (in_ch),
        .out_mon   (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // Receiver: switches at random among four ready patterns; one long hold on request.
    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 400 == 0)
            rx_mode = $urandom_range(0, 3);
        if (hold_req && !hold_done) begin
            hold_done = 1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       out_ch.ready <= 1'b1;                           // no stall
                1:       out_ch.ready <= ($urandom_range(0, 1) == 0);
                2:       out_ch.ready <= ($urandom_range(0, 7) == 0);    // mostly stalled
                default: out_ch.ready <= ((rx_cycle / 13) % 3 != 0);     // periodic
            endcase
        end
    end

    // Watchdog: any handshake restarts the count.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // New grid settings; only called with nothing in flight.
    task automatic set_grid(input longint ox, input longint oy, input longint oz,
                            input longint sx, input longint sy, input longint sz);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_SIZE_X, sx);
        write_reg(CFG_SIZE_Y, sy);
        write_reg(CFG_SIZE_Z, sz);
        cur_org = '{ox, oy, oz};
        cur_sz  = '{sx, sy, sz};
    endtask

    // Ends an open burst, then waits for every result.
    task automatic drain();
        if (burst_left != 0)
        begin
            in_ch.valid <= 1'b0;
            burst_left = 0;
        end
        while (pending != 0) @(posedge clk);
        repeat (20) @(negedge clk);
    endtask

    // One item: bursts of back-to-back items, random gaps between bursts.
    task automatic send_item(input logic act, input longint x, input longint y,
                             input longint z, input longint pid);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.coord_x     <= x[COORD_W-1:0];
        in_ch.coord_y     <= y[COORD_W-1:0];
        in_ch.coord_z     <= z[COORD_W-1:0];
        in_ch.point_ident <= pid[ID_W-1:0];
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
        if (burst_left == 0)
            in_ch.valid <= 1'b0;
    endtask

    // One coordinate on axis a: mostly inside the grid, some just below the
    // origin (truncation keeps them in cell 0), some anywhere.
    function automatic longint pick_coord(int a);
        longint v;
        int     sel;
        sel = $urandom_range(0, 9);
        if (sel < 8)
            v = cur_org[a] + longint'($urandom_range(0, int'(cur_sz[a] * GRID_N - 1)));
        else if (sel == 8)
            v = cur_org[a] - longint'($urandom_range(0, int'(cur_sz[a] - 1)));
        else
            v = longint'(signed'($urandom_range(0, 32'hFFFFFF) << 8) >>> 8);
        if (v > 8388607 || v < -8388608)
            v = longint'(signed'($urandom_range(0, 32'hFFFFFF) << 8) >>> 8);
        return v;
    endfunction

    function automatic longint pick_ident();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3) return -1;                 // take the running counter
        if (sel == 3) return 1048575;
        if (sel == 4) return 0;
        return longint'($urandom_range(0, 1048575));
    endfunction

    task automatic random_items(input int count, input int query_pct);
        logic act;
        for (int n = 0; n < count; n++) begin
            act = ($urandom_range(0, 99) < query_pct);
            send_item(act, pick_coord(0), pick_coord(1), pick_coord(2), pick_ident());
        end
    endtask

    initial
    begin
        in_ch.valid       = 1'b0;
        in_ch.action      = 1'b0;
        in_ch.coord_x     = '0;
        in_ch.coord_y     = '0;
        in_ch.coord_z     = '0;
        in_ch.point_ident = '0;
        out_ch.ready      = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        burst_left        = 0;
        hold_req          = 0;
        hold_done         = 0;
        hold_left         = 0;
        rx_cycle          = 0;
        rx_mode           = 0;
        idle_cycles       = 0;
        cur_org           = '{0, 0, 0};
        cur_sz            = '{256, 256, 256};
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // ---- directed part on the reset grid: cells of 1.0 from 0.0 to 8.0 ----
        send_item(1'b1, 100, 100, 100, 0);              // query on an empty grid
        send_item(1'b0, -8388608, 0, 0, 3);             // add below the x bound
        send_item(1'b0, 0, 0, 0, 5);
        send_item(1'b0, -255, 10, 10, -1);              // slightly negative, lands in cell 0
        send_item(1'b0, 2047, 2047, 2047, 1048575);     // top corner cell
        send_item(1'b0, 8388607, 8388607, 8388607, 7);  // add above every bound
        send_item(1'b1, 0, 0, 0, -1);                   // exact hit in own cell
        send_item(1'b1, 1000, 1000, 1000, 0);           // empty cell, cube growth
        send_item(1'b1, -8388608, -8388608, -8388608, 0); // query out of bounds
        for (int n = 0; n < 9; n++)                     // fill one cell, ninth add is full
            send_item(1'b0, 300, 300, 300, -1);
        send_item(1'b1, 300, 300, 300, 0);              // all equal: earliest point wins
        send_item(1'b1, 520, 520, 520, 0);              // neighbor recheck across cells
        send_item(1'b1, 2047, 0, 0, 0);
        send_item(1'b1, 1500, 1900, 2000, 0);
        // pause until every result is back
        drain();

        random_items(400, 40);

        // ---- widest cells from the lowest origin: everything in two cells per axis ----
        drain();
        set_grid(-8388608, -8388608, -8388608, 16777215, 16777215, 16777215);
        random_items(100, 50);

        // ---- narrowest cells at the top of the range ----
        drain();
        set_grid(8388607, 8388607, 8388607, 1, 1, 1);
        send_item(1'b0, 8388607, 8388607, 8388607, -1);
        send_item(1'b1, 8388607, 8388607, 8388607, 0);
        random_items(40, 50);

        // ---- mid-size cells at a random origin; one long receiver hold ----
        drain();
        set_grid(longint'($urandom_range(0, 2000000)) - 1000000,
                 longint'($urandom_range(0, 2000000)) - 1000000,
                 longint'($urandom_range(0, 2000000)) - 1000000,
                 $urandom_range(16, 4096), $urandom_range(16, 4096),
                 $urandom_range(1, 65536));
        hold_req = 1;   // sender keeps offering while the result channel is held
        random_items(550, 35);

        drain();
        repeat (1000) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
src/gbn_pkg.sv
src/gbn_intf.sv
src/gbn_div.sv
src/gbn_sqrt.sv
src/grid_bucket_nearest_point.sv
tb/gbn_checker.sv
tb/tb_grid_bucket_nearest_point.sv
